/* rtl/icrk4_pkg.sv */
`default_nettype none
package icrk4_pkg;

   localparam int MAX_STATES_DEF = 32;
   localparam int ACC_W = 64;
   localparam int MAG_W = 59;
   localparam int DIV_NUM_W = 60;
   localparam int DIV_DEN_W = 16;

   localparam logic signed [ACC_W-1:0] ACC_LIM = 64'sd576460752303423487;
   localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

   localparam logic CSR_NUM_ITER = 1'b0;
   localparam logic CSR_TOTAL_TIME = 1'b1;

   typedef struct packed {
      logic                    start;
      logic signed [ACC_W-1:0] x;
      logic [31:0]             r;
   } mul_req_type;

   typedef struct packed {
      logic             done;
      logic             neg;
      logic [MAG_W-1:0] mag;
   } mul_rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quo;
   } div_rsp_type;

   function automatic logic signed [ACC_W-1:0] clamp_acc(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] r;
      r = v;
      if (v > ACC_LIM) r = ACC_LIM;
      else if (v < -ACC_LIM) r = -ACC_LIM;
      return r;
   endfunction

   function automatic logic signed [31:0] clamp_pop(input logic signed [ACC_W-1:0] v);
      logic signed [31:0] r;
      r = v[31:0];
      if (v > 64'sd2147483647) r = 32'sh7fffffff;
      else if (v < -64'sd2147483648) r = 32'sh80000000;
      return r;
   endfunction

endpackage
`default_nettype wire

/* rtl/ionization_chain_rk4_solver_unit.sv */
// Ionization chain rate solver (RK4 over a sequential chain of charge states).
// Requests carry one Q8.24 rate each; each accepted request is stored in the
// rate memory. The request with last_state set (or the one filling the final
// slot) starts a solve and req_ready stays low until all results have left.
// A solve divides total_time by num_iterations (on the serial divider, skipped
// when num_iterations is 0), sets the populations, then runs num_iterations
// sub-steps, each walking all states. Per state and sub-step there is one load
// step, one shared 32x32 multiplier does eight Q.30 by Q8.24 products, and the
// divide by six takes four reciprocal digit steps.
// Results then leave one per state; a low rsp_ready holds the current result.
// Configuration is written through csr_write/csr_index/csr_wdata, by the user
// and only while idle; the block itself does not enforce this.
// Reset: num_iterations 1, total_time 0, no rates loaded, no result pending.
`default_nettype none
module ionization_chain_rk4_solver_unit import icrk4_pkg::*; #(
   parameter int MAX_STATES = MAX_STATES_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [31:0]        req_rate,
   input  wire logic               req_last_state,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_cumulative_prob,
   output logic [5:0]              rsp_state_index,
   output logic                    rsp_last_result,
   input  wire logic               csr_write,
   input  wire logic               csr_index,
   input  wire logic [31:0]        csr_wdata
);

   localparam int IW = $clog2(MAX_STATES);
   localparam int CW = $clog2(MAX_STATES + 1);
   // ceil(2^20 / 3): exact floor(x / 3) for x below 2^18
   localparam logic [19:0] THIRD_RECIP = 20'h55556;

   typedef enum logic [12:0] {
      S_IDLE    = 13'b0000000000001,
      S_HDIV    = 13'b0000000000010,
      S_INIT    = 13'b0000000000100,
      S_LOAD    = 13'b0000000001000,
      S_SLOPE   = 13'b0000000010000,
      S_SLOPE_W = 13'b0000000100000,
      S_STEP    = 13'b0000001000000,
      S_STEP_W  = 13'b0000010000000,
      S_FIN     = 13'b0000100000000,
      S_FIN_W   = 13'b0001000000000,
      S_DIV6_W  = 13'b0010000000000,
      S_CUM     = 13'b0100000000000,
      S_OUT     = 13'b1000000000000
   } st_type;

   st_type st_ff, st_in;
   logic [31:0] rate_mem [MAX_STATES];
   logic signed [31:0] pop_mem [MAX_STATES];
   logic [31:0] rate_rd_ff;
   logic signed [31:0] pop_rd_ff;

   logic [IW-1:0] fill_ff, fill_in;
   logic [CW-1:0] count_ff, count_in, z_ff, z_in;
   logic [15:0] iter_ff, iter_in, num_iter_ff;
   logic [31:0] total_time_ff, h_ff, h_in, w_ff, w_in;
   logic signed [31:0] n_ff, n_in, acc_ff, acc_in;
   logic signed [ACC_W-1:0] gain_ff, gain_in, nw_ff, nw_in, y_ff, y_in;
   logic signed [ACC_W-1:0] k_ff, k_in, sum_ff, sum_in;
   logic [1:0] phase_ff, phase_in;
   logic pneg_ff, pneg_in;
   logic [63:0] d6_num_ff, d6_num_in;
   logic [47:0] d6_quo_ff, d6_quo_in;
   logic [1:0] d6_rem_ff, d6_rem_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic signed [31:0] rsp_cum_ff, rsp_cum_in;
   logic [5:0] rsp_idx_ff, rsp_idx_in;

   logic pop_we;
   logic signed [31:0] pop_wdata;
   logic req_acc, last_eff;
   logic [IW-1:0] zi, zn;

   mul_req_type mul_req;
   mul_rsp_type mul_rsp;
   div_req_type div_req;
   div_rsp_type div_rsp;

   icrk4_mul u_mul (.clock(clock), .reset(reset), .req(mul_req), .rsp(mul_rsp));
   icrk4_div u_div (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));

   assign req_ready = (st_ff == S_IDLE);
   assign req_acc = req_valid && req_ready;
   assign last_eff = req_last_state || (fill_ff == IW'(MAX_STATES - 1));
   assign zi = z_ff[IW-1:0];
   assign zn = z_in[IW-1:0];

   always_comb begin
      logic signed [ACC_W-1:0] t, half, q, k;
      logic [17:0] cur, r3;
      logic [37:0] qprod;
      logic [15:0] qd;
      t = mul_rsp.neg ? -$signed({5'b0, mul_rsp.mag}) : $signed({5'b0, mul_rsp.mag});
      half = $signed({5'b0, mul_rsp.mag});
      k = clamp_acc(gain_ff - t);
      // one base-2^16 digit of the divide by three per cycle
      cur = {d6_rem_ff, d6_num_ff[63:48]};
      qprod = 38'(cur) * 38'(THIRD_RECIP);
      qd = qprod[35:20];
      r3 = cur - (18'(qd) + 18'({qd, 1'b0}));
      q = $signed({d6_quo_ff, qd});
      st_in = st_ff;
      fill_in = fill_ff;
      count_in = count_ff;
      z_in = z_ff;
      iter_in = iter_ff;
      h_in = h_ff;
      w_in = w_ff;
      n_in = n_ff;
      acc_in = acc_ff;
      gain_in = gain_ff;
      nw_in = nw_ff;
      y_in = y_ff;
      k_in = k_ff;
      sum_in = sum_ff;
      phase_in = phase_ff;
      pneg_in = pneg_ff;
      d6_num_in = d6_num_ff;
      d6_quo_in = d6_quo_ff;
      d6_rem_in = d6_rem_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_cum_in = rsp_cum_ff;
      rsp_idx_in = rsp_idx_ff;
      rsp_last_in = rsp_last_ff;
      pop_we = 1'b0;
      pop_wdata = '0;
      mul_req = '0;
      div_req = '0;
      case (st_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (last_eff) begin
                  count_in = CW'(fill_ff) + CW'(1);
                  fill_in = '0;
                  z_in = '0;
                  if (num_iter_ff == 16'd0) begin
                     h_in = '0;
                     st_in = S_INIT;
                  end else begin
                     div_req.start = 1'b1;
                     div_req.num = DIV_NUM_W'(total_time_ff);
                     div_req.den = num_iter_ff;
                     st_in = S_HDIV;
                  end
               end else begin
                  fill_in = fill_ff + IW'(1);
               end
            end
         end
         S_HDIV: begin
            if (div_rsp.done) begin
               h_in = div_rsp.quo[31:0];
               st_in = S_INIT;
            end
         end
         S_INIT: begin
            pop_we = 1'b1;
            pop_wdata = (z_ff == '0) ? ONE_Q30 : '0;
            z_in = z_ff + CW'(1);
            if (z_ff + CW'(1) == count_ff) begin
               z_in = '0;
               iter_in = '0;
               gain_in = '0;
               acc_in = '0;
               st_in = (num_iter_ff == 16'd0) ? S_CUM : S_LOAD;
            end
         end
         S_LOAD: begin
            n_in = pop_rd_ff;
            w_in = rate_rd_ff;
            y_in = ACC_W'(pop_rd_ff);
            phase_in = '0;
            sum_in = '0;
            st_in = S_SLOPE;
         end
         S_SLOPE: begin
            mul_req = '{start: 1'b1, x: y_ff, r: w_ff};
            st_in = S_SLOPE_W;
         end
         S_SLOPE_W: begin
            if (mul_rsp.done) begin
               if (phase_ff == 2'd0) nw_in = t;
               k_in = k;
               sum_in = sum_ff + ((phase_ff == 2'd1 || phase_ff == 2'd2) ? (k <<< 1) : k);
               st_in = (phase_ff == 2'd3) ? S_FIN : S_STEP;
            end
         end
         S_STEP: begin
            mul_req = '{start: 1'b1, x: k_ff, r: h_ff};
            st_in = S_STEP_W;
         end
         S_STEP_W: begin
            if (mul_rsp.done) begin
               if (phase_ff != 2'd2) half = half >>> 1;
               y_in = clamp_acc(ACC_W'(n_ff) + (mul_rsp.neg ? -half : half));
               phase_in = phase_ff + 2'd1;
               st_in = S_SLOPE;
            end
         end
         S_FIN: begin
            mul_req = '{start: 1'b1, x: clamp_acc(sum_ff), r: h_ff};
            st_in = S_FIN_W;
         end
         S_FIN_W: begin
            if (mul_rsp.done) begin
               pneg_in = mul_rsp.neg;
               // divide by six: halve, then divide by three
               d6_num_in = {6'b0, mul_rsp.mag[MAG_W-1:1]};
               d6_rem_in = '0;
               d6_quo_in = '0;
               phase_in = '0;
               st_in = S_DIV6_W;
            end
         end
         S_DIV6_W: begin
            d6_num_in = {d6_num_ff[47:0], 16'b0};
            d6_rem_in = r3[1:0];
            d6_quo_in = {d6_quo_ff[31:0], qd};
            phase_in = phase_ff + 2'd1;
            if (phase_ff == 2'd3) begin
               pop_we = 1'b1;
               pop_wdata = clamp_pop(ACC_W'(n_ff) + (pneg_ff ? -q : q));
               gain_in = nw_ff;
               z_in = z_ff + CW'(1);
               st_in = S_LOAD;
               if (z_ff + CW'(1) == count_ff) begin
                  z_in = '0;
                  gain_in = '0;
                  iter_in = iter_ff + 16'd1;
                  if (iter_ff + 16'd1 == num_iter_ff) begin
                     acc_in = '0;
                     st_in = S_CUM;
                  end
               end
            end
         end
         S_CUM: begin
            rsp_cum_in = clamp_pop(ACC_W'(acc_ff) + ACC_W'(pop_rd_ff));
            rsp_idx_in = 6'(zi);
            rsp_last_in = (z_ff + CW'(1) == count_ff);
            rsp_valid_in = 1'b1;
            st_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               acc_in = rsp_cum_ff;
               z_in = z_ff + CW'(1);
               st_in = rsp_last_ff ? S_IDLE : S_CUM;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         fill_ff <= '0;
         num_iter_ff <= 16'd1;
         total_time_ff <= '0;
         rsp_valid_ff <= 1'b0;
         h_ff <= '0;
      end else begin
         st_ff <= st_in;
         fill_ff <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         h_ff <= h_in;
         if (csr_write) begin
            case (csr_index)
               CSR_NUM_ITER:   num_iter_ff <= csr_wdata[15:0];
               CSR_TOTAL_TIME: total_time_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      count_ff <= count_in;
      z_ff <= z_in;
      iter_ff <= iter_in;
      w_ff <= w_in;
      n_ff <= n_in;
      acc_ff <= acc_in;
      gain_ff <= gain_in;
      nw_ff <= nw_in;
      y_ff <= y_in;
      k_ff <= k_in;
      sum_ff <= sum_in;
      phase_ff <= phase_in;
      pneg_ff <= pneg_in;
      d6_num_ff <= d6_num_in;
      d6_quo_ff <= d6_quo_in;
      d6_rem_ff <= d6_rem_in;
      rsp_cum_ff <= rsp_cum_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   // read data follows the next state index; a same-cycle population write is forwarded
   always_ff @(posedge clock) begin
      if (req_acc) rate_mem[fill_ff] <= req_rate;
      if (pop_we) pop_mem[zi] <= pop_wdata;
      rate_rd_ff <= rate_mem[zn];
      pop_rd_ff <= (pop_we && zi == zn) ? pop_wdata : pop_mem[zn];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cumulative_prob = rsp_cum_ff;
   assign rsp_state_index = rsp_idx_ff;
   assign rsp_last_result = rsp_last_ff;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("request taken while result pending");

   a_mul_expected: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> (st_ff == S_SLOPE_W || st_ff == S_STEP_W || st_ff == S_FIN_W))
      else $error("multiplier result outside a wait state");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_result |=> req_ready)
      else $error("block not ready after final result");

endmodule
`default_nettype wire

/* rtl/icrk4_mul.sv */
`default_nettype none
module icrk4_mul import icrk4_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mul_req_type req,
   output mul_rsp_type      rsp
);

   typedef enum logic [3:0] {
      M_IDLE = 4'b0001,
      M_LO   = 4'b0010,
      M_HI   = 4'b0100,
      M_FIN  = 4'b1000
   } mst_type;

   mst_type st_ff, st_in;
   logic neg_ff, neg_in;
   logic [26:0] hi_ff, hi_in;
   logic [31:0] lo_ff, lo_in, r_ff, r_in;
   logic [63:0] plo_ff, plo_in;
   logic [58:0] phi_ff, phi_in;
   logic done_ff, done_in;
   logic [MAG_W-1:0] mag_ff, mag_in;
   logic [31:0] op_a;
   logic [63:0] prod;

   assign op_a = (st_ff == M_HI) ? {5'b0, hi_ff} : lo_ff;
   assign prod = op_a * r_ff;

   always_comb begin
      logic signed [ACC_W-1:0] cx;
      logic [ACC_W-1:0] m;
      logic [59:0] s;
      cx = clamp_acc(req.x);
      m = (cx < 0) ? 64'(-cx) : 64'(cx);
      s = 60'({phi_ff[50:0], 8'b0}) + 60'(plo_ff[63:24]);
      st_in = st_ff;
      neg_in = neg_ff;
      hi_in = hi_ff;
      lo_in = lo_ff;
      r_in = r_ff;
      plo_in = plo_ff;
      phi_in = phi_ff;
      mag_in = mag_ff;
      done_in = 1'b0;
      case (st_ff)
         M_IDLE: begin
            if (req.start) begin
               neg_in = cx < 0;
               hi_in = m[58:32];
               lo_in = m[31:0];
               r_in = req.r;
               st_in = M_LO;
            end
         end
         M_LO: begin
            plo_in = prod;
            st_in = M_HI;
         end
         M_HI: begin
            phi_in = prod[58:0];
            st_in = M_FIN;
         end
         M_FIN: begin
            if (phi_ff >= (59'd1 << 51) || s > 60'(ACC_LIM)) mag_in = ACC_LIM[MAG_W-1:0];
            else mag_in = s[MAG_W-1:0];
            done_in = 1'b1;
            st_in = M_IDLE;
         end
         default: st_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= M_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
      r_ff <= r_in;
      plo_ff <= plo_in;
      phi_ff <= phi_in;
      mag_ff <= mag_in;
   end

   assign rsp = '{done: done_ff, neg: neg_ff, mag: mag_ff};

endmodule
`default_nettype wire

/* rtl/icrk4_div.sv */
`default_nettype none
module icrk4_div import icrk4_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);

   logic busy_ff, busy_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic done_ff, done_in;
   logic [DIV_DEN_W:0] rsh;

   assign rsh = {rem_ff[DIV_DEN_W-1:0], quo_ff[DIV_NUM_W-1]};

   always_comb begin
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      done_in = 1'b0;
      if (!busy_ff) begin
         if (req.start) begin
            busy_in = 1'b1;
            cnt_in = 6'(DIV_NUM_W - 1);
            quo_in = req.num;
            rem_in = '0;
            den_in = req.den;
         end
      end else begin
         if (rsh >= {1'b0, den_ff}) begin
            rem_in = rsh - {1'b0, den_ff};
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rsh;
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp = '{done: done_ff, quo: quo_ff};

endmodule
`default_nettype wire

/* tb/ionization_chain_rk4_solver_unit_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module ionization_chain_rk4_solver_unit_tb import icrk4_pkg::*;;

   localparam int CHAIN_MAX = 32;
   localparam longint SLOPE_MAX = 64'sd576460752303423487;
   localparam longint POP_ONE = 64'sd1073741824;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int RANDOM_ITEMS = 470;

   typedef struct {
      logic signed [31:0] prob;
      logic [5:0]         index;
      logic               last;
   } chain_result_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [31:0] req_rate;
   logic req_last_state;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [31:0] rsp_cumulative_prob;
   logic [5:0] rsp_state_index;
   logic rsp_last_result;
   logic csr_write;
   logic csr_index;
   logic [31:0] csr_wdata;

   chain_result_type pending_results[$];
   logic [15:0] model_iterations;
   logic [31:0] model_total_time;
   logic [31:0] model_rates[CHAIN_MAX];
   int model_loaded;

   int mismatches;
   int cycles;
   int items_sent;
   int burst_left;
   int stall_hold;
   int stall_mode;

   ionization_chain_rk4_solver_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_rate(req_rate),
      .req_last_state(req_last_state),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_cumulative_prob(rsp_cumulative_prob),
      .rsp_state_index(rsp_state_index),
      .rsp_last_result(rsp_last_result),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic longint sat_slope(longint v);
      if (v > SLOPE_MAX) return SLOPE_MAX;
      if (v < -SLOPE_MAX) return -SLOPE_MAX;
      return v;
   endfunction

   function automatic logic signed [31:0] sat_pop(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // Q.30 times unsigned Q8.24, magnitude truncated, saturating
   function automatic longint scale_by_rate(longint x, logic [31:0] r);
      longint cx;
      logic neg;
      logic [63:0] mag;
      logic [63:0] upper;
      logic [63:0] prod;
      cx = sat_slope(x);
      neg = cx < 0;
      mag = neg ? -cx : cx;
      upper = (mag >> 32) * {32'b0, r};
      if (upper >= (64'd1 << 51)) begin
         prod = SLOPE_MAX;
      end else begin
         prod = (upper << 8) + (({32'b0, mag[31:0]} * {32'b0, r}) >> 24);
         if (prod > SLOPE_MAX) prod = SLOPE_MAX;
      end
      return neg ? -longint'(prod) : longint'(prod);
   endfunction

   function automatic longint decay_slope(longint gain, logic [31:0] w, longint n);
      return sat_slope(gain - scale_by_rate(n, w));
   endfunction

   task automatic predict_chain(input int count);
      logic [31:0] step;
      logic signed [31:0] pop[CHAIN_MAX];
      longint gain, n, k1, k2, k3, k4, sum;
      chain_result_type res;
      step = (model_iterations == 0) ? 32'd0 : model_total_time / model_iterations;
      pop[0] = 32'(POP_ONE);
      for (int z = 1; z < count; z++) pop[z] = '0;
      for (int it = 0; it < model_iterations; it++) begin
         gain = 0;
         for (int z = 0; z < count; z++) begin
            n = pop[z];
            k1 = decay_slope(gain, model_rates[z], n);
            k2 = decay_slope(gain, model_rates[z],
                             sat_slope(n + scale_by_rate(k1, step) / 2));
            k3 = decay_slope(gain, model_rates[z],
                             sat_slope(n + scale_by_rate(k2, step) / 2));
            k4 = decay_slope(gain, model_rates[z], sat_slope(n + scale_by_rate(k3, step)));
            sum = sat_slope(k1 + 2 * k2 + 2 * k3 + k4);
            pop[z] = sat_pop(n + scale_by_rate(sum, step) / 6);
            gain = scale_by_rate(n, model_rates[z]);
         end
      end
      for (int z = 1; z < count; z++) pop[z] = sat_pop(longint'(pop[z]) + longint'(pop[z-1]));
      for (int z = 0; z < count; z++) begin
         res.prob = pop[z];
         res.index = 6'(z);
         res.last = (z + 1 == count);
         pending_results.push_back(res);
      end
   endtask

   task automatic load_rate(input logic [31:0] rate, input logic last);
      int idx;
      idx = model_loaded;
      model_rates[idx] = rate;
      if (!last && idx + 1 < CHAIN_MAX) begin
         model_loaded = idx + 1;
      end else begin
         model_loaded = 0;
         predict_chain(idx + 1);
      end
   endtask

   // called at a falling edge; returns at a falling edge
   task automatic send_rate(input logic [31:0] rate, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_rate <= rate;
      req_last_state <= last;
      do @(posedge clock); while (!req_ready);
      load_rate(rate, last);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic write_reg(input logic index, input logic [31:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      if (index == CSR_NUM_ITER) model_iterations = value[15:0];
      else model_total_time = value;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic send_chain(input int len, input logic end_flag, input int rate_bits);
      logic [31:0] r;
      for (int i = 0; i < len; i++) begin
         r = (rate_bits >= 32) ? $urandom : $urandom_range(0, (1 << rate_bits) - 1);
         send_rate(r, (i == len - 1) ? end_flag : 1'b0);
      end
   endtask

   task automatic test_reset_values();
      send_chain(3, 1'b1, 26);
      drain_results();
   endtask

   task automatic test_zero_substeps();
      write_reg(CSR_NUM_ITER, 32'd0);
      write_reg(CSR_TOTAL_TIME, 32'hffffffff);
      send_chain(4, 1'b1, 32);
      drain_results();
   endtask

   task automatic test_field_extremes();
      write_reg(CSR_NUM_ITER, 32'd65535);
      write_reg(CSR_NUM_ITER, 32'd1);
      send_rate(32'h0, 1'b0);
      send_rate(32'hffffffff, 1'b0);
      send_rate(32'h0100_0000, 1'b1);
      drain_results();
      write_reg(CSR_NUM_ITER, 32'd2);
      write_reg(CSR_TOTAL_TIME, 32'h0200_0000);
      send_rate(32'hffffffff, 1'b0);
      send_rate(32'hffffffff, 1'b1);
      send_rate(32'h0080_0000, 1'b1);
      drain_results();
   endtask

   task automatic test_many_substeps();
      write_reg(CSR_NUM_ITER, 32'd1000);
      write_reg(CSR_TOTAL_TIME, 32'h0400_0000);
      send_rate(32'h0180_0000, 1'b1);
      drain_results();
   endtask

   task automatic test_chain_overflow();
      write_reg(CSR_NUM_ITER, 32'd1);
      write_reg(CSR_TOTAL_TIME, 32'h0010_0000);
      send_chain(CHAIN_MAX, 1'b0, 26);
      send_chain(2, 1'b1, 26);
      send_chain(CHAIN_MAX, 1'b1, 26);
      drain_results();
   endtask

   task automatic test_output_stall();
      write_reg(CSR_NUM_ITER, 32'd1);
      stall_hold = 800;
      send_chain(5, 1'b1, 26);
      send_chain(3, 1'b1, 26);
      send_chain(2, 1'b1, 26);
      drain_results();
   endtask

   task automatic test_random_chains();
      int len;
      logic end_flag;
      while (items_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0) begin
            drain_results();
            write_reg(CSR_NUM_ITER, ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4));
            write_reg(CSR_TOTAL_TIME, ($urandom_range(0, 7) == 0) ? $urandom
                                                                 : $urandom_range(0, 1 << 26));
         end
         if ($urandom_range(0, 19) == 0) begin
            len = CHAIN_MAX;
            end_flag = $urandom_range(0, 1);
         end else begin
            len = $urandom_range(1, 6);
            end_flag = 1'b1;
         end
         send_chain(len, end_flag, ($urandom_range(0, 7) == 0) ? 32 : $urandom_range(8, 26));
      end
      drain_results();
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
         rsp_ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= $urandom_range(0, 1);
            default: rsp_ready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      chain_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: prob %h index %0d last %b",
                        rsp_cumulative_prob, rsp_state_index, rsp_last_result);
         end else begin
            want = pending_results.pop_front();
            if (rsp_cumulative_prob !== want.prob || rsp_state_index !== want.index ||
                rsp_last_result !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected prob %h index %0d last %b, got %h %0d %b",
                           want.prob, want.index, want.last,
                           rsp_cumulative_prob, rsp_state_index, rsp_last_result);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("ionization_chain_rk4_solver_unit_tb: FAIL");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_rate = 32'h0;
      req_last_state = 1'b0;
      rsp_ready = 1'b0;
      csr_write = 1'b0;
      csr_index = CSR_NUM_ITER;
      csr_wdata = 32'h0;
      mismatches = 0;
      cycles = 0;
      items_sent = 0;
      burst_left = 0;
      stall_hold = 0;
      stall_mode = 0;
      model_iterations = 16'd1;
      model_total_time = 32'd0;
      model_loaded = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_values();
      test_zero_substeps();
      test_field_extremes();
      test_many_substeps();
      test_chain_overflow();
      test_output_stall();
      test_random_chains();
      repeat (50) @(negedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("ionization_chain_rk4_solver_unit_tb: PASS");
      end else begin
         $display("ionization_chain_rk4_solver_unit_tb: FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire

/* filelist.f */
rtl/icrk4_pkg.sv
rtl/icrk4_mul.sv
rtl/icrk4_div.sv
rtl/ionization_chain_rk4_solver_unit.sv
tb/ionization_chain_rk4_solver_unit_tb.sv
